### sv/gblur_pkg.sv
`default_nettype none

package gblur_pkg;

	localparam int RADIUS     = 2;
	localparam int SPAN       = 2 * RADIUS + 1;
	localparam int LINES      = 2 * RADIUS;
	localparam int LANE_W     = $clog2(LINES);
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int WGT_W  = 16;
	localparam int RES_W  = 16;

	// weight groups, one per distinct squared distance
	localparam int NGRP    = 6;
	localparam int GRP_W   = 3;
	localparam int GSUM_W  = PIX_W + 3;
	localparam int PROD_W  = GSUM_W + WGT_W;
	localparam int SUM_W   = 32;
	localparam int FRAC_SH = 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D0    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D1    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D2    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D4    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D5    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D8    = 4'd7;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
	localparam logic [WGT_W-1:0] WEIGHT_D0_RST    = 16'd10317;
	localparam logic [WGT_W-1:0] WEIGHT_D1_RST    = 16'd7880;
	localparam logic [WGT_W-1:0] WEIGHT_D2_RST    = 16'd6018;
	localparam logic [WGT_W-1:0] WEIGHT_D4_RST    = 16'd2682;
	localparam logic [WGT_W-1:0] WEIGHT_D5_RST    = 16'd2049;
	localparam logic [WGT_W-1:0] WEIGHT_D8_RST    = 16'd695;

	typedef logic [LINES-1:0][PIX_W-1:0] lanes_t;
	typedef logic [NGRP-1:0][GSUM_W-1:0] gsum_t;
	typedef logic [NGRP-1:0][WGT_W-1:0]  weights_t;

	typedef struct packed {
		logic              we;
		logic              adv;
		logic [COL_W-1:0]  addr;
		logic [LANE_W-1:0] lane;
		logic [PIX_W-1:0]  wdata;
	} lb_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} meta_t;

	// weight group of a tap; NGRP means no weight
	function automatic logic [GRP_W-1:0] grp_of(int dy, int dx);
		int d;
		d = dy * dy + dx * dx;
		case (d)
			0:       return GRP_W'(0);
			1:       return GRP_W'(1);
			2:       return GRP_W'(2);
			4:       return GRP_W'(3);
			5:       return GRP_W'(4);
			8:       return GRP_W'(5);
			default: return GRP_W'(NGRP);
		endcase
	endfunction

endpackage

`default_nettype wire

### sv/gblur_ifs.sv
`default_nettype none

interface gblur_pix_if;
	logic                         valid;
	logic                         ready;
	logic [gblur_pkg::PIX_W-1:0]  pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface gblur_res_if;
	logic                         valid;
	logic                         ready;
	logic [gblur_pkg::RES_W-1:0]  blurred;
	logic [gblur_pkg::ROW_W-1:0]  out_row;
	logic [gblur_pkg::COL_W-1:0]  out_col;
	logic                         frame_done;

	modport source (output valid, output blurred, output out_row, output out_col,
		output frame_done, input ready);
	modport sink   (input valid, input blurred, input out_row, input out_col,
		input frame_done, output ready);
endinterface

`default_nettype wire

### sv/gblur_line_buf.sv
`default_nettype none

module gblur_line_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  gblur_pkg::lb_req_t req,
	output gblur_pkg::lanes_t  rdata_s1,
	output logic               busy
);

	// one word per column holding every line, each line a byte lane
	gblur_pkg::lanes_t           mem [gblur_pkg::MAX_WIDTH];
	logic [gblur_pkg::COL_W-1:0] clr_addr_q;
	logic                        busy_q;

	// clearing pass: one column of every line per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + gblur_pkg::COL_W'(1);
			if (clr_addr_q == gblur_pkg::COL_W'(gblur_pkg::MAX_WIDTH - 1))
				busy_q <= 1'b0;
		end
	end

	// read-first: the column read returns the older rows before this write lands
	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_addr_q] <= '0;
		else if (req.we)
			mem[req.addr][req.lane] <= req.wdata;
		if (req.adv)
			rdata_s1 <= mem[req.addr];
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

### sv/gblur_window.sv
`default_nettype none

module gblur_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         shift,
	input  gblur_pkg::lanes_t            lanes_s1,
	input  logic [gblur_pkg::LANE_W-1:0] lane_s1,
	input  logic [gblur_pkg::PIX_W-1:0]  px_s1,
	output gblur_pkg::gsum_t             gsum_s3
);

	logic [gblur_pkg::PIX_W-1:0] taps_q [gblur_pkg::SPAN][gblur_pkg::SPAN];
	logic [gblur_pkg::PIX_W-1:0] col    [gblur_pkg::SPAN];
	gblur_pkg::gsum_t            gsum;

	// oldest line first; newest pixel at the bottom
	always_comb begin
		for (int i = 0; i < gblur_pkg::LINES; i++)
			col[i] = lanes_s1[lane_s1 + gblur_pkg::LANE_W'(i)];
		col[gblur_pkg::LINES] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gblur_pkg::SPAN; i++)
				for (int j = 0; j < gblur_pkg::SPAN; j++)
					taps_q[i][j] <= '0;
		end else if (adv && shift) begin
			for (int i = 0; i < gblur_pkg::SPAN; i++) begin
				for (int j = 0; j + 1 < gblur_pkg::SPAN; j++)
					taps_q[i][j] <= taps_q[i][j+1];
				taps_q[i][gblur_pkg::SPAN-1] <= col[i];
			end
		end
	end

	// taps sharing a weight are added before the multiply
	always_comb begin
		for (int g = 0; g < gblur_pkg::NGRP; g++) begin
			gsum[g] = '0;
			for (int i = 0; i < gblur_pkg::SPAN; i++)
				for (int j = 0; j < gblur_pkg::SPAN; j++)
					if (gblur_pkg::grp_of(i - gblur_pkg::RADIUS, j - gblur_pkg::RADIUS)
						== gblur_pkg::GRP_W'(g))
						gsum[g] = gsum[g] + gblur_pkg::GSUM_W'(taps_q[i][j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			gsum_s3 <= gsum;
	end

endmodule

`default_nettype wire

### sv/gblur_mac.sv
`default_nettype none

module gblur_mac (
	input  logic                        clk,
	input  logic                        adv,
	input  gblur_pkg::gsum_t            gsum_s3,
	input  gblur_pkg::weights_t         weights,
	output logic [gblur_pkg::SUM_W-1:0] sum_s5
);

	logic [gblur_pkg::PROD_W-1:0] prod_s4 [gblur_pkg::NGRP];
	logic [gblur_pkg::SUM_W-1:0]  sum;

	always_comb begin
		sum = '0;
		for (int g = 0; g < gblur_pkg::NGRP; g++)
			sum = sum + gblur_pkg::SUM_W'(prod_s4[g]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < gblur_pkg::NGRP; g++)
				prod_s4[g] <= gblur_pkg::PROD_W'(gsum_s3[g])
					* gblur_pkg::PROD_W'(weights[g]);
			sum_s5 <= sum;
		end
	end

endmodule

`default_nettype wire

### sv/gaussian_blur_2d_window.sv
// 5x5 Gaussian blur on a raster pixel stream.
// pix: one 8-bit grayscale pixel per transfer, raster order, frame size from
// the frame_width / frame_height registers. res: one Q8.8 result per interior
// pixel (at least RADIUS from every edge) with its row, column and a mark on
// the last interior pixel of the frame; border pixels give no transfer.
// cfg_we/cfg_idx/cfg_wdata write the size and the six symmetric Q0.16
// weights; write them only while the stream is idle.
// Throughput: one pixel per cycle while res is not stalled and the clearing
// pass is over. Steps: line-buffer read at the pixel's transfer, then window
// shift, group add, multiply, sum, round/saturate.
// Reset: registers take their default frame and weights, counters return to
// the top-left, and the line buffers are cleared one column per cycle over
// all MAX_WIDTH (1024) columns; pix.ready stays low during that pass.
// Stall: the whole pipe holds while a result waits on res; pix.ready follows
// res.ready combinationally, so a new pixel is still taken in the same cycle
// a waiting result leaves.
`default_nettype none

module gaussian_blur_2d_window (
	input  logic                              clk,
	input  logic                              arst_n,
	gblur_pix_if.sink                         pix,
	gblur_res_if.source                       res,
	input  logic                              cfg_we,
	input  logic [gblur_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [gblur_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic [gblur_pkg::FW_W-1:0] width_q;
	logic [gblur_pkg::FH_W-1:0] height_q;
	gblur_pkg::weights_t        weights_q;

	logic [gblur_pkg::FW_W-1:0] w_eff;
	logic [gblur_pkg::FH_W-1:0] h_eff;
	logic [gblur_pkg::COL_W-1:0] col_q;
	logic [gblur_pkg::ROW_W-1:0] row_q;
	logic [gblur_pkg::FW_W-1:0] col_inc;
	logic [gblur_pkg::FH_W-1:0] row_inc;

	logic adv;
	logic acc;
	logic clr_busy;
	logic interior;

	gblur_pkg::lb_req_t lb_req;
	gblur_pkg::lanes_t  lanes_s1;
	gblur_pkg::gsum_t   gsum_s3;
	logic [gblur_pkg::SUM_W-1:0] sum_s5;
	logic [gblur_pkg::SUM_W-1:0] rnd;

	gblur_pkg::meta_t meta_in;
	gblur_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic vld_s1;
	logic emit_s1, emit_s2, emit_s3, emit_s4, emit_s5;
	logic [gblur_pkg::LANE_W-1:0] lane_s1;
	logic [gblur_pkg::PIX_W-1:0]  px_s1;

	logic                        out_valid_q;
	logic [gblur_pkg::RES_W-1:0] blurred_q;
	gblur_pkg::meta_t            meta_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= gblur_pkg::FRAME_WIDTH_RST;
			height_q     <= gblur_pkg::FRAME_HEIGHT_RST;
			weights_q[0] <= gblur_pkg::WEIGHT_D0_RST;
			weights_q[1] <= gblur_pkg::WEIGHT_D1_RST;
			weights_q[2] <= gblur_pkg::WEIGHT_D2_RST;
			weights_q[3] <= gblur_pkg::WEIGHT_D4_RST;
			weights_q[4] <= gblur_pkg::WEIGHT_D5_RST;
			weights_q[5] <= gblur_pkg::WEIGHT_D8_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gblur_pkg::REG_FRAME_WIDTH:  width_q      <= cfg_wdata[gblur_pkg::FW_W-1:0];
				gblur_pkg::REG_FRAME_HEIGHT: height_q     <= cfg_wdata[gblur_pkg::FH_W-1:0];
				gblur_pkg::REG_WEIGHT_D0:    weights_q[0] <= cfg_wdata;
				gblur_pkg::REG_WEIGHT_D1:    weights_q[1] <= cfg_wdata;
				gblur_pkg::REG_WEIGHT_D2:    weights_q[2] <= cfg_wdata;
				gblur_pkg::REG_WEIGHT_D4:    weights_q[3] <= cfg_wdata;
				gblur_pkg::REG_WEIGHT_D5:    weights_q[4] <= cfg_wdata;
				gblur_pkg::REG_WEIGHT_D8:    weights_q[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = gblur_pkg::FW_W'(1);
		else if (width_q > gblur_pkg::FW_W'(gblur_pkg::MAX_WIDTH))
			w_eff = gblur_pkg::FW_W'(gblur_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = gblur_pkg::FH_W'(1);
		else if (height_q > gblur_pkg::FH_W'(gblur_pkg::MAX_HEIGHT))
			h_eff = gblur_pkg::FH_W'(gblur_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// handshake: the output register is the only point of back-pressure; the clearing pass also holds pix.ready low
	assign adv       = !out_valid_q || res.ready;
	assign pix.ready = adv && !clr_busy;
	assign acc       = pix.valid && pix.ready;

	assign col_inc  = gblur_pkg::FW_W'(col_q) + gblur_pkg::FW_W'(1);
	assign row_inc  = gblur_pkg::FH_W'(row_q) + gblur_pkg::FH_W'(1);
	assign interior = (row_q >= gblur_pkg::ROW_W'(gblur_pkg::LINES))
		&& (col_q >= gblur_pkg::COL_W'(gblur_pkg::LINES));

	always_comb begin
		meta_in.row  = row_q - gblur_pkg::ROW_W'(gblur_pkg::RADIUS);
		meta_in.col  = col_q - gblur_pkg::COL_W'(gblur_pkg::RADIUS);
		meta_in.done = (row_inc == h_eff) && (col_inc == w_eff);
	end

	// position of the next pixel; a shrunk size wraps on the next accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				if (row_inc >= h_eff)
					row_q <= '0;
				else
					row_q <= row_inc[gblur_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[gblur_pkg::COL_W-1:0];
			end
		end
	end

	always_comb begin
		lb_req.we    = acc;
		lb_req.adv   = adv;
		lb_req.addr  = col_q;
		lb_req.lane  = row_q[gblur_pkg::LANE_W-1:0];
		lb_req.wdata = pix.pixel;
	end

	gblur_line_buf u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (lb_req),
		.rdata_s1 (lanes_s1),
		.busy     (clr_busy)
	);

	gblur_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.shift    (vld_s1),
		.lanes_s1 (lanes_s1),
		.lane_s1  (lane_s1),
		.px_s1    (px_s1),
		.gsum_s3  (gsum_s3)
	);

	gblur_mac u_mac (
		.clk     (clk),
		.adv     (adv),
		.gsum_s3 (gsum_s3),
		.weights (weights_q),
		.sum_s5  (sum_s5)
	);

	// control pipeline alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
			emit_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= acc;
			emit_s1 <= acc && interior;
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
			emit_s5 <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_in;
			lane_s1 <= row_q[gblur_pkg::LANE_W-1:0];
			px_s1   <= pix.pixel;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	// round half up, then saturate to Q8.8
	assign rnd = sum_s5 + gblur_pkg::SUM_W'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= emit_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q <= meta_s5;
			if (|rnd[gblur_pkg::SUM_W-1:gblur_pkg::FRAC_SH+gblur_pkg::RES_W])
				blurred_q <= '1;
			else
				blurred_q <= rnd[gblur_pkg::FRAC_SH+gblur_pkg::RES_W-1:gblur_pkg::FRAC_SH];
		end
	end

	assign res.valid      = out_valid_q;
	assign res.blurred    = blurred_q;
	assign res.out_row    = meta_q.row;
	assign res.out_col    = meta_q.col;
	assign res.frame_done = meta_q.done;

endmodule

`default_nettype wire
